@@ src/sk2hid_pkg.sv @@
// ----------------------------------------------------------------------------
// sk2hid_pkg
// Shared types, constants and the serial-code to HID usage table.
// ----------------------------------------------------------------------------
`default_nettype none

package sk2hid_pkg;

  localparam int CODE_W        = 7;
  localparam int USAGE_W       = 8;
  localparam int IDLE_W        = 10;
  localparam int REPORT_USAGES = 6;
  localparam int TABLE_ENTRIES = 127;
  localparam int REL_BIT       = 7;
  localparam int APB_AW        = 3;
  localparam int APB_DW        = 32;

  localparam logic [IDLE_W-1:0]  IDLE_PERIOD_RESET = 10'd500;
  localparam logic [USAGE_W-1:0] USAGE_CLEAR       = 8'h9C;
  localparam logic [USAGE_W-1:0] USAGE_MOD_FIRST   = 8'hE0;
  localparam logic [USAGE_W-1:0] USAGE_MOD_LAST    = 8'hE7;

  // Item kinds
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // Register index, taken from paddr[2]
  localparam logic REG_IDLE_PERIOD = 1'b0;

  typedef logic [CODE_W-1:0]  slot_t;
  typedef logic [USAGE_W-1:0] usage_t;

  typedef struct packed {
    logic   [7:0]               modifiers;
    usage_t [REPORT_USAGES-1:0] usages;
  } report_t;

  // Key code applied to the slots on a poll
  typedef struct packed {
    logic       apply;
    logic [7:0] code;
  } slot_cmd_t;

  localparam usage_t USAGE_TABLE [0:127] = '{
    8'h00, 8'h32, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23,
    8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E, 8'h00, 8'h2A,
    8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18,
    8'h0C, 8'h12, 8'h13, 8'h2F, 8'h30, 8'h31, 8'h39, 8'h04,
    8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F,
    8'h33, 8'h34, 8'h00, 8'h28, 8'hE1, 8'h00, 8'h1D, 8'h1B,
    8'h06, 8'h19, 8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38,
    8'h9C, 8'hE5, 8'hE0, 8'h00, 8'hE2, 8'h2C, 8'hE6, 8'h00,
    8'hE4, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h49, 8'h4C, 8'h00, 8'h00, 8'h50,
    8'h4A, 8'h4D, 8'h00, 8'h52, 8'h51, 8'h4B, 8'h4E, 8'h00,
    8'h00, 8'h4F, 8'h53, 8'h5F, 8'h5C, 8'h59, 8'h00, 8'h54,
    8'h60, 8'h5D, 8'h5A, 8'h62, 8'h55, 8'h61, 8'h5E, 8'h5B,
    8'h63, 8'h56, 8'h57, 8'h58, 8'h00, 8'h00, 8'h29, 8'h00,
    8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41,
    8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h00
  };

endpackage

`default_nettype wire

@@ src/sk2hid_slots.sv @@
// ----------------------------------------------------------------------------
// sk2hid_slots
// Held-key slot register with press, release and clear-all update.
// ----------------------------------------------------------------------------
`default_nettype none

module sk2hid_slots
  import sk2hid_pkg::*;
#(
  parameter int SLOT_COUNT = 6
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire slot_cmd_t cmd,
  output slot_t          slots_next [SLOT_COUNT]
);

  slot_t slots [SLOT_COUNT];
  slot_t code7;
  logic  found;
  logic  is_release;
  logic  is_clear;
  logic  is_press;
  logic  same_next;
  logic  code_in_next;
  logic  any_next;

  assign code7      = cmd.code[CODE_W-1:0];
  assign is_release = cmd.code[REL_BIT];
  assign is_clear   = !is_release && (cmd.code < 8'(TABLE_ENTRIES))
                      && (USAGE_TABLE[code7] == USAGE_CLEAR);
  assign is_press   = !is_release && (cmd.code < 8'(TABLE_ENTRIES))
                      && !is_clear && (code7 != '0);

  always_comb begin
    slots_next = slots;
    found      = 1'b0;
    if (cmd.apply) begin
      if (is_release) begin
        // first match only; code zero hits an empty slot and changes nothing
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!found && slots[i] == code7) begin
            slots_next[i] = '0;
            found         = 1'b1;
          end
        end
      end else if (is_clear) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          slots_next[i] = '0;
        end
      end else if (is_press) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!found) begin
            if (slots[i] == code7) begin
              found = 1'b1;
            end else if (slots[i] == '0) begin
              slots_next[i] = code7;
              found         = 1'b1;
            end
          end
        end
        // all full: slot 0 is overwritten
        if (!found) begin
          slots_next[0] = code7;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slots[i] <= '0;
      end
    end else begin
      slots <= slots_next;
    end
  end

  // Checks on the update
  always_comb begin
    same_next    = 1'b1;
    code_in_next = 1'b0;
    any_next     = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slots_next[i] != '0) begin
        any_next = 1'b1;
      end
      if (slots_next[i] == code7) begin
        code_in_next = 1'b1;
      end
      if (slots_next[i] != slots[i]) begin
        same_next = 1'b0;
      end
    end
  end

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !cmd.apply |-> same_next)
    else $error("sk2hid_slots: slots changed with no code applied");

  a_press_held: assert property (@(posedge clk) disable iff (rst)
    cmd.apply && is_press |-> code_in_next)
    else $error("sk2hid_slots: pressed code not held");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.apply && is_clear |=> !$past(any_next))
    else $error("sk2hid_slots: clear left a slot occupied");

endmodule

`default_nettype wire

@@ src/sk2hid_report.sv @@
// ----------------------------------------------------------------------------
// sk2hid_report
// Translates held slots to HID usages, packs them and sets modifier bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sk2hid_report
  import sk2hid_pkg::*;
#(
  parameter int SLOT_COUNT = 6
) (
  input  wire slot_t slots [SLOT_COUNT],
  output report_t    rep
);

  localparam int POS_W = $clog2(REPORT_USAGES + 1);

  usage_t           usage [SLOT_COUNT];
  logic             occ   [SLOT_COUNT];
  logic [POS_W-1:0] pos   [SLOT_COUNT];
  logic [POS_W-1:0] count;

  always_comb begin
    count = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      usage[i] = USAGE_TABLE[slots[i]];
      occ[i]   = (slots[i] != '0);
      pos[i]   = count;
      if (occ[i]) begin
        count = count + 1'b1;
      end
    end
  end

  always_comb begin
    rep = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (usage[i] >= USAGE_MOD_FIRST && usage[i] <= USAGE_MOD_LAST) begin
        rep.modifiers[usage[i][2:0]] = 1'b1;
      end
      for (int j = 0; j < REPORT_USAGES; j++) begin
        if (occ[i] && pos[i] == POS_W'(j)) begin
          rep.usages[j] = usage[i];
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ src/serial_key_to_hid_report_top.sv @@
// ----------------------------------------------------------------------------
// serial_key_to_hid_report_top
// Serial key codes to USB HID boot keyboard reports, six-key rollover.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item (op, has_byte, serial_code, endpoint_ready) is
//   taken on a clock edge with start high and busy low. busy never rises, so
//   one item may be issued every cycle.
//   A tick (op = 0) counts the idle timer down and gives no result.
//   A poll (op = 1) applies the optional key code, builds the report and
//   gives one result transfer, marked by done, after the item has passed
//   through the input register and then the result register.
//   Throughput: one item per cycle; the slot update and table lookup sit in
//   one combinational stage between the input and result registers.
//   Results are shown for one cycle only; there is no back-pressure, so the
//   receiver must take each transfer as it comes.
//   Configuration: APB, idle_period at byte address 0 (10 bits, reset 500,
//   zero disables periodic resend). Write only while no poll is in flight.
//   Reset: synchronous, active high. Slots empty, last report zero, idle
//   timer zero, so the first poll after reset always sends (endpoint ready).
// ----------------------------------------------------------------------------
`default_nettype none

module serial_key_to_hid_report_top
  import sk2hid_pkg::*;
#(
  parameter int SLOT_COUNT = 6
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // command channel
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              op,
  input  wire logic              has_byte,
  input  wire logic [7:0]        serial_code,
  input  wire logic              endpoint_ready,
  // result channel
  output logic                   done,
  output logic                   report_send,
  output logic [7:0]             modifiers,
  output logic [7:0]             usage_0,
  output logic [7:0]             usage_1,
  output logic [7:0]             usage_2,
  output logic [7:0]             usage_3,
  output logic [7:0]             usage_4,
  output logic [7:0]             usage_5,
  output logic                   echo_valid,
  output logic [7:0]             echo_byte,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  // --- input register ---
  logic        item_valid;
  logic        item_op;
  logic        item_has;
  logic [7:0]  item_code;
  logic        item_ready;

  // --- state ---
  logic [IDLE_W-1:0] idle_period;
  logic [IDLE_W-1:0] idle_left;
  logic [IDLE_W-1:0] idle_left_next;
  report_t           last_report;

  // --- datapath ---
  logic       poll;
  logic       tick;
  logic       idle_due;
  logic       send;
  slot_cmd_t  cmd;
  slot_t      slots_next [SLOT_COUNT];
  report_t    rep;
  logic       cfg_write;

  // Every cycle can take a transfer; the pipeline has no stall point.
  assign busy   = 1'b0;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_op    <= op;
      item_has   <= has_byte;
      item_code  <= serial_code;
      item_ready <= endpoint_ready;
    end
  end

  assign poll = item_valid && (item_op == OP_POLL);
  assign tick = item_valid && (item_op == OP_TICK);

  // key code only counts on a poll
  assign cmd.apply = poll && item_has;
  assign cmd.code  = item_code;

  sk2hid_slots #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_slots (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .slots_next (slots_next)
  );

  // report is built from the slots after this poll's code is applied
  sk2hid_report #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_report (
    .slots (slots_next),
    .rep   (rep)
  );

  // Idle timer: expiry forces a send and reloads, even if the endpoint
  // is not ready (in which case nothing goes out).
  assign idle_due = (idle_period != '0) && (idle_left == '0);
  assign send     = (idle_due || (rep != last_report)) && item_ready;

  always_comb begin
    idle_left_next = idle_left;
    if (tick && idle_left != '0) begin
      idle_left_next = idle_left - 1'b1;
    end else if (poll && idle_due) begin
      idle_left_next = idle_period;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_left   <= '0;
      last_report <= '0;
    end else begin
      idle_left <= idle_left_next;
      if (poll && send) begin
        last_report <= rep;
      end
    end
  end

  // --- configuration port ---
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_period <= IDLE_PERIOD_RESET;
    end else if (cfg_write && paddr[2] == REG_IDLE_PERIOD) begin
      idle_period <= pwdata[IDLE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_IDLE_PERIOD) begin
      prdata = APB_DW'(idle_period);
    end
  end

  // --- result register ---
  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      report_send <= 1'b0;
      echo_valid  <= 1'b0;
    end else begin
      done        <= poll;
      report_send <= poll && send;
      echo_valid  <= poll && item_has;
    end
  end

  always_ff @(posedge clk) begin
    modifiers <= rep.modifiers;
    usage_0   <= rep.usages[0];
    usage_1   <= rep.usages[1];
    usage_2   <= rep.usages[2];
    usage_3   <= rep.usages[3];
    usage_4   <= rep.usages[4];
    usage_5   <= rep.usages[5];
    echo_byte <= item_has ? ~item_code : 8'h00;
  end

  // --- checks ---
  a_done_after_poll: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(poll))
    else $error("top: result transfer without a poll");

  a_send_with_done: assert property (@(posedge clk) disable iff (rst)
    report_send |-> done)
    else $error("top: report_send outside a result transfer");

  a_last_matches: assert property (@(posedge clk) disable iff (rst)
    done && report_send |-> last_report.modifiers == modifiers
      && last_report.usages[0] == usage_0 && last_report.usages[1] == usage_1
      && last_report.usages[2] == usage_2 && last_report.usages[3] == usage_3
      && last_report.usages[4] == usage_4 && last_report.usages[5] == usage_5)
    else $error("top: sent report not recorded as last report");

endmodule

`default_nettype wire

@@ verif/hid_report_checker.sv @@
// ----------------------------------------------------------------------------
// hid_report_checker
// Watches the command, result and APB channels of the serial key to HID
// report block, keeps its own copy of the key slots and idle timer, and
// compares every result transfer with the report it should carry.
// ----------------------------------------------------------------------------
module hid_report_checker
  import sk2hid_pkg::*;
#(
  parameter int SLOT_COUNT = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic              op,
  input  logic              has_byte,
  input  logic [7:0]        serial_code,
  input  logic              endpoint_ready,
  input  logic              done,
  input  logic              report_send,
  input  logic [7:0]        modifiers,
  input  logic [7:0]        usage_0,
  input  logic [7:0]        usage_1,
  input  logic [7:0]        usage_2,
  input  logic [7:0]        usage_3,
  input  logic [7:0]        usage_4,
  input  logic [7:0]        usage_5,
  input  logic              echo_valid,
  input  logic [7:0]        echo_byte,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic [APB_DW-1:0] prdata,
  input  logic              pready,
  output int                fail_count,
  output int                in_flight,
  output int                reports_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                  send;
    logic [7:0]            mods;
    logic [5:0][USAGE_W-1:0] keys;
    logic                  echo_v;
    logic [7:0]            echo;
  } poll_result_t;

  logic [CODE_W-1:0] held [SLOT_COUNT];
  logic [55:0]       last_sent;
  logic [IDLE_W-1:0] idle_left;
  logic [IDLE_W-1:0] idle_period;

  poll_result_t pending_reports [$];
  int errors = 0;
  int compared = 0;

  assign fail_count   = errors;
  assign reports_seen = compared;

  function automatic void clear_keys();
    for (int i = 0; i < SLOT_COUNT; i++) held[i] = '0;
  endfunction

  // first matching slot only
  function automatic void release_key(logic [CODE_W-1:0] key);
    bit hit;
    hit = 0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!hit && held[i] == key) begin
        held[i] = '0;
        hit = 1;
      end
    end
  endfunction

  // already held: no change; else first empty slot; else slot 0
  function automatic void press_key(logic [CODE_W-1:0] key);
    bit placed;
    placed = 0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!placed) begin
        if (held[i] == key) begin
          placed = 1;
        end else if (held[i] == '0) begin
          held[i] = key;
          placed = 1;
        end
      end
    end
    if (!placed) held[0] = key;
  endfunction

  function automatic poll_result_t predict_poll(logic hb, logic [7:0] code, logic rdy);
    poll_result_t r;
    logic [CODE_W-1:0] key;
    logic [USAGE_W-1:0] u;
    int used;
    key = code[CODE_W-1:0];
    if (hb) begin
      if (code[REL_BIT]) begin
        release_key(key);
      end else if (int'(code) < TABLE_ENTRIES) begin
        if (USAGE_TABLE[key] == USAGE_CLEAR) clear_keys();
        else if (key != '0) press_key(key);
      end
    end
    r = '0;
    used = 0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      u = USAGE_TABLE[held[i]];
      if (held[i] != '0 && used < REPORT_USAGES) begin
        r.keys[used] = u;
        used++;
      end
      if (u >= USAGE_MOD_FIRST && u <= USAGE_MOD_LAST) r.mods[u[2:0]] = 1'b1;
    end
    if (idle_period != '0 && idle_left == '0) begin
      idle_left = idle_period;
      r.send = 1'b1;
    end else begin
      r.send = ({r.mods, r.keys} != last_sent);
    end
    r.send = r.send & rdy;
    if (r.send) last_sent = {r.mods, r.keys};
    r.echo_v = hb;
    r.echo   = hb ? ~code : 8'h00;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    poll_result_t want;
    if (rst) begin
      clear_keys();
      last_sent   = '0;
      idle_left   = '0;
      idle_period = IDLE_PERIOD_RESET;
      pending_reports.delete();
    end else begin
      // result first: it belongs to the oldest poll still pending
      if (done === 1'b1) begin
        if (pending_reports.size() == 0) begin
          $error("result transfer with no poll outstanding");
          errors++;
        end else begin
          want = pending_reports.pop_front();
          check_field("report_send", 8'(want.send), 8'(report_send));
          check_field("modifiers", want.mods, modifiers);
          check_field("usage_0", want.keys[0], usage_0);
          check_field("usage_1", want.keys[1], usage_1);
          check_field("usage_2", want.keys[2], usage_2);
          check_field("usage_3", want.keys[3], usage_3);
          check_field("usage_4", want.keys[4], usage_4);
          check_field("usage_5", want.keys[5], usage_5);
          check_field("echo_valid", 8'(want.echo_v), 8'(echo_valid));
          check_field("echo_byte", want.echo, echo_byte);
          compared++;
        end
      end
      if (psel && penable && pready && paddr[2] == REG_IDLE_PERIOD) begin
        if (pwrite) begin
          idle_period = pwdata[IDLE_W-1:0];
        end else if (prdata !== APB_DW'(idle_period)) begin
          $error("idle_period read: expected 0x%08h, got 0x%08h",
                 APB_DW'(idle_period), prdata);
          errors++;
        end
      end
      if (start && !busy) begin
        if (op == OP_POLL) begin
          pending_reports.push_back(predict_poll(has_byte, serial_code, endpoint_ready));
        end else if (idle_left != '0) begin
          idle_left--;
        end
      end
    end
    in_flight <= pending_reports.size();
  end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Top of the serial key to HID report testbench. Drives key presses,
// releases, clears and idle ticks through the command channel, reprograms
// the idle period over APB between phases, and leaves all checking to
// hid_report_checker.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sk2hid_pkg::*;

  localparam int SLOTS       = 6;
  localparam int PHASE_ITEMS = 85;
  localparam int CYCLE_LIMIT = 200000;

  // idle_period is register 0, selected by paddr[2]
  localparam logic [APB_AW-1:0] IDLE_PERIOD_ADDR = {REG_IDLE_PERIOD, 2'b00};

  // codes that map onto modifier usages (shift, ctrl and alt variants)
  localparam logic [6:0] MOD_CODES [6] = '{7'd44, 7'd57, 7'd58, 7'd60, 7'd62, 7'd64};
  localparam logic [7:0] CODE_CLEAR    = 8'd56;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              op = OP_TICK;
  logic              has_byte = 1'b0;
  logic [7:0]        serial_code = 8'h00;
  logic              endpoint_ready = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;

  logic              busy, done, report_send, echo_valid, pready;
  logic [7:0]        modifiers, usage_0, usage_1, usage_2, usage_3, usage_4, usage_5;
  logic [7:0]        echo_byte;
  logic [APB_DW-1:0] prdata;

  int fail_count, in_flight, reports_seen;

  // stimulus bookkeeping
  int         burst_left = 0;
  int         items_sent = 0;
  int         polls_sent = 0;
  int         settings_used = 0;
  int         cycles = 0;
  logic [6:0] key_pool [8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  serial_key_to_hid_report_top #(.SLOT_COUNT(SLOTS)) dut (
    .clk, .rst, .start, .busy, .op, .has_byte, .serial_code, .endpoint_ready,
    .done, .report_send, .modifiers, .usage_0, .usage_1, .usage_2, .usage_3,
    .usage_4, .usage_5, .echo_valid, .echo_byte,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  hid_report_checker #(.SLOT_COUNT(SLOTS)) u_checker (
    .clk, .rst, .start, .busy, .op, .has_byte, .serial_code, .endpoint_ready,
    .done, .report_send, .modifiers, .usage_0, .usage_1, .usage_2, .usage_3,
    .usage_4, .usage_5, .echo_valid, .echo_byte,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fail_count, .in_flight, .reports_seen
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // One command transfer. Bursts of back-to-back transfers are broken by
  // random gaps; start is dropped only when a gap opens, so it never gets two
  // updates in one step. Fields are scrambled during a gap to check that the
  // block ignores them while start is low.
  task automatic push_item(input logic o, input logic hb, input logic [7:0] code,
                           input logic rdy);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start       <= 1'b0;
        op          <= 1'($urandom);
        serial_code <= 8'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start          <= 1'b1;
    op             <= o;
    has_byte       <= hb;
    serial_code    <= code;
    endpoint_ready <= rdy;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (o == OP_POLL) polls_sent++;
  endtask

  // Close the current burst and wait for every poll to come back. Ticks give
  // no result, so the closing wait covers one still in the pipe.
  task automatic drain();
    start      <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Setup and access phase; the trailing idle cycle keeps psel from being
  // dropped and raised in the same step when accesses follow each other.
  task automatic apb_access(input logic wr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= IDLE_PERIOD_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // New idle period, written with the block idle and read back.
  task automatic set_idle_period(input logic [IDLE_W-1:0] period);
    drain();
    apb_access(1'b1, APB_DW'(period));
    apb_access(1'b0, '0);
    settings_used++;
  endtask

  // Most codes come from a small pool so that presses and releases meet,
  // with some clears, edge codes and fully random bytes mixed in.
  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50)      return {1'b0, key_pool[$urandom_range(0, 7)]};
    else if (r < 80) return {1'b1, key_pool[$urandom_range(0, 7)]};
    else if (r < 85) return CODE_CLEAR;
    else if (r < 87) return 8'h00;
    else if (r < 89) return 8'h7F;
    else if (r < 90) return 8'h80;
    else if (r < 91) return 8'hFF;
    else             return 8'($urandom);
  endfunction

  task automatic random_phase(input logic [IDLE_W-1:0] period);
    set_idle_period(period);
    for (int i = 0; i < 8; i++) begin
      key_pool[i] = (i < 3) ? MOD_CODES[$urandom_range(0, 5)] : 7'($urandom_range(1, 126));
    end
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if ($urandom_range(0, 99) < 35) begin
        // ticks carry junk in the byte fields
        push_item(OP_TICK, 1'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        push_item(OP_POLL, $urandom_range(0, 99) < 85, pick_code(),
                  $urandom_range(0, 99) < 80);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset value of idle_period, then directed sequence under it
    apb_access(1'b0, '0);

    // idle timer starts at zero: reload happens even though nothing is sent
    push_item(OP_POLL, 1'b0, 8'h00, 1'b0);
    // empty report equals the last one sent, timer running: no transfer
    push_item(OP_POLL, 1'b0, 8'h00, 1'b1);
    // byte on a tick is ignored
    push_item(OP_TICK, 1'b1, 8'd44, 1'b1);
    // left shift, a plain key, then the same key again
    push_item(OP_POLL, 1'b1, 8'd44, 1'b1);
    push_item(OP_POLL, 1'b1, 8'd4, 1'b1);
    push_item(OP_POLL, 1'b1, 8'd4, 1'b1);
    // held code with no usage still takes a slot
    push_item(OP_POLL, 1'b1, 8'd14, 1'b1);
    // modifiers fill the slots, then two presses overwrite slot 0
    push_item(OP_POLL, 1'b1, 8'd57, 1'b1);
    push_item(OP_POLL, 1'b1, 8'd58, 1'b1);
    push_item(OP_POLL, 1'b1, 8'd60, 1'b1);
    push_item(OP_POLL, 1'b1, 8'd62, 1'b1);
    push_item(OP_POLL, 1'b1, 8'd64, 1'b1);
    // code beyond the table and code zero are both ignored
    push_item(OP_POLL, 1'b1, 8'h7F, 1'b1);
    push_item(OP_POLL, 1'b1, 8'h00, 1'b1);
    // release of code zero with no empty slot, then a real release
    push_item(OP_POLL, 1'b1, 8'h80, 1'b1);
    push_item(OP_POLL, 1'b1, 8'h84, 1'b1);
    // release of code zero now hits the empty slot: no change
    push_item(OP_POLL, 1'b1, 8'h80, 1'b1);
    push_item(OP_POLL, 1'b1, 8'd126, 1'b1);
    // release of a code that is not held
    push_item(OP_POLL, 1'b1, 8'hFF, 1'b1);
    // clear while the endpoint is busy, then the cleared report goes out
    push_item(OP_POLL, 1'b1, CODE_CLEAR, 1'b0);
    push_item(OP_POLL, 1'b0, 8'h00, 1'b1);

    // random phases over a spread of idle periods, extremes included
    random_phase(10'd1);
    random_phase(10'd0);
    random_phase(10'd1020);
    random_phase(10'd1023);
    random_phase(IDLE_W'($urandom_range(2, 8)));
    random_phase(IDLE_W'($urandom_range(0, 1023)));

    drain();
    repeat (8) @(posedge clk);

    $display("Covered %0d command transfers (%0d polls, %0d ticks) over %0d idle periods.",
             items_sent, polls_sent, items_sent - polls_sent, settings_used + 1);
    $display("Compared %0d result transfers; %0d mismatches.", reports_seen, fail_count);
    if (fail_count == 0 && in_flight == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
